>>> rtl/core/pepu_pkg.sv
`default_nettype none
package pepu_pkg;

  localparam int unsigned NumCircuitsDef = 32;
  localparam int unsigned WindowLenDef   = 4;
  localparam int unsigned MembersDef     = 5;

  localparam logic signed [31:0] OneQ16   = 32'sd65536;
  localparam logic signed [31:0] WinReset = 32'sd1;

  typedef enum logic [1:0] {
    OpPush    = 2'd0,
    OpPredict = 2'd1,
    OpTrain   = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StHash,
    StPush,
    StSumInit,
    StSumRead,
    StSumMac,
    StSumDone,
    StHidPush,
    StTrainRead,
    StTrainWrite,
    StOut
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/pepu_req_if.sv
`default_nettype none
interface pepu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] vaddr;
  logic [31:0] value;
  logic [2:0]  member;
  modport source(output valid, op, vaddr, value, member, input ready);
  modport sink(input valid, op, vaddr, value, member, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pepu_rsp_if.sv
`default_nettype none
interface pepu_rsp_if;
  logic        valid;
  logic        ready;
  logic        epoch_end;
  logic [31:0] score;
  modport source(output valid, epoch_end, score, input ready);
  modport sink(input valid, epoch_end, score, output ready);
endinterface
`default_nettype wire

>>> rtl/core/perceptron_epoch_predictor_unit.sv
`default_nettype none
// Push and predict words, and train words with a valid member and a nonzero value, first
// fold address bits 63:4 into a circuit index. Predict then sums each member in turn;
// each term is a read, a registered multiply and an add. One word is in flight at a time.
// After reset a clearing pass fills the memories with their initial values; no word is
// accepted during it. Reset is asynchronous.
module perceptron_epoch_predictor_unit #(
  parameter int unsigned NUM_CIRCUITS = pepu_pkg::NumCircuitsDef,
  parameter int unsigned WINDOW_LEN   = pepu_pkg::WindowLenDef,
  parameter int unsigned MEMBERS      = pepu_pkg::MembersDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  pepu_req_if.sink         req,
  pepu_rsp_if.source       rsp
);
  import pepu_pkg::*;

  localparam int unsigned Rows = NUM_CIRCUITS * MEMBERS;
  localparam int unsigned RW   = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned CW   = (NUM_CIRCUITS > 1) ? $clog2(NUM_CIRCUITS) : 1;
  localparam int unsigned MW   = $clog2(MEMBERS);
  localparam int unsigned NW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned KW   = $clog2(WINDOW_LEN + 1);
  localparam int unsigned WAW  = $clog2(Rows * (WINDOW_LEN + 1));
  localparam int unsigned XAW  = (Rows * WINDOW_LEN > 1) ? $clog2(Rows * WINDOW_LEN) : 1;
  localparam int unsigned CntW = (WAW > RW + 1) ? WAW : RW + 1;
  localparam logic [MW-1:0] LastM = MW'(MEMBERS - 1);
  localparam logic [KW-1:0] LastK = KW'(WINDOW_LEN);

  // The circuit index is reduced 15 address bits per cycle. Each step takes the
  // running remainder times 2^15 plus the next chunk and reduces it modulo
  // NUM_CIRCUITS by a reciprocal multiplication that is exact for HD-bit values.
  localparam int unsigned HD  = CW + 15;
  localparam int unsigned HL  = $clog2(NUM_CIRCUITS);
  localparam int unsigned HPW = 2 * HD + 1;
  localparam logic [63:0] HashRecip =
    ((64'd1 << (HD + HL)) + 64'(NUM_CIRCUITS) - 64'd1) / 64'(NUM_CIRCUITS);

  // The training step is the parameter divided by WINDOW_LEN, truncated toward
  // zero: the magnitude is divided by a reciprocal multiplication and the sign
  // is put back afterwards.
  localparam int unsigned DL = $clog2(WINDOW_LEN);
  localparam logic [63:0] DivRecip =
    ((64'd1 << (32 + DL)) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);

  // Memories; each is read and written in clocked blocks, one port.
  logic signed [31:0] wmem [Rows*(WINDOW_LEN+1)];
  logic signed [31:0] xmem [Rows*WINDOW_LEN];
  logic signed [31:0] smem [Rows];
  logic [NW-1:0]      pmem [Rows];

  state_e state_q, state_d;
  op_e op_q;
  logic signed [31:0] thr_q;
  logic [CW-1:0] circ_q;
  logic [59:0] addr_q;
  logic [MW-1:0] mem_q;
  logic [KW-1:0] k_q;
  logic [CntW-1:0] clr_q;
  logic signed [31:0] val_q, delta_q;
  logic signed [65:0] acc_q;
  logic [NW-1:0] ptr_q;
  logic [1:0] ph_q;
  logic eo_q;
  logic signed [31:0] score_q;
  logic signed [31:0] wrd_q, xrd_q, srd_q;
  logic [NW-1:0] prd_q;
  logic signed [47:0] term;

  logic [HD-1:0]  hash_t;
  logic [HPW-1:0] hash_p;
  logic [HD-1:0]  hash_quo;
  logic [HD-1:0]  hash_r;
  logic [31:0]    val_mag;
  logic [64:0]    dprod;
  logic [31:0]    dquo;

  assign hash_t   = {circ_q, addr_q[59:45]};
  assign hash_p   = HPW'(hash_t) * HPW'(HashRecip[HD:0]);
  assign hash_quo = HD'(hash_p >> (HD + HL));
  assign hash_r   = hash_t - HD'(hash_quo * NUM_CIRCUITS);

  assign val_mag = val_q[31] ? 32'(~val_q + 32'sd1) : 32'(val_q);
  assign dprod   = 65'(val_mag) * 65'(DivRecip[32:0]);
  assign dquo    = 32'(dprod >> (32 + DL));

  logic [RW-1:0] row;
  logic [WAW-1:0] waddr;
  logic [XAW-1:0] xaddr;
  assign row   = RW'(circ_q * MEMBERS + mem_q);
  assign waddr = WAW'(row * (WINDOW_LEN + 1) + k_q);
  assign xaddr = XAW'(row * WINDOW_LEN + ((k_q == '0) ? '0 : k_q - 1'b1));

  pepu_mac u_mac (.clk_i(clk_i), .a_i(xrd_q), .b_i(wrd_q), .term_o(term));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:      if (clr_q == CntW'(Rows - 1) && k_q == LastK) state_d = StIdle;
      StIdle: begin
        if (req.valid) begin
          unique case (op_e'(req.op))
            OpPush:    state_d = StHash;
            OpPredict: state_d = StHash;
            OpTrain:   if (32'(req.member) < MEMBERS && req.value != '0)
                         state_d = StHash;
            default:   state_d = StIdle;
          endcase
        end
      end
      StHash: begin
        if (ph_q == 2'd3) begin
          unique case (op_q)
            OpPush:    state_d = StPush;
            OpPredict: state_d = StSumInit;
            OpTrain:   state_d = StTrainRead;
            default:   state_d = StIdle;
          endcase
        end
      end
      StPush:       if (ph_q == 2'd1 && mem_q == LastM) state_d = StIdle;
      StSumInit:    state_d = StSumRead;
      StSumRead:    if (ph_q == 2'd2) state_d = StSumMac;
      StSumMac:     state_d = (k_q == LastK) ? StSumDone : StSumRead;
      StSumDone:    state_d = (mem_q == LastM) ? StOut
                             : (mem_q == MW'(MEMBERS - 2)) ? StHidPush : StSumInit;
      StHidPush:    if (ph_q == 2'd1 && mem_q == MW'(MEMBERS - 2)) state_d = StSumInit;
      StTrainRead:  state_d = StTrainWrite;
      StTrainWrite: state_d = (k_q == LastK) ? StIdle : StTrainRead;
      StOut:        if (rsp.ready) state_d = StIdle;
      default:      state_d = StIdle;
    endcase
  end

  always_comb begin
    req.ready     = (state_q == StIdle);
    rsp.valid     = (state_q == StOut);
    rsp.epoch_end = eo_q;
    rsp.score     = score_q;
  end

  // Hidden-sum push walks mem_q over source members while writing the last window.
  logic [RW-1:0] lrow;
  assign lrow = RW'(circ_q * MEMBERS + LastM);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StClear: begin
        wmem[WAW'(clr_q[RW-1:0] * (WINDOW_LEN + 1) + k_q)] <= OneQ16;
        if (k_q != LastK) xmem[XAW'(clr_q[RW-1:0] * WINDOW_LEN + k_q)] <= WinReset;
        if (k_q == '0) begin
          smem[clr_q[RW-1:0]] <= '0;
          pmem[clr_q[RW-1:0]] <= '0;
        end
      end
      StPush: begin
        if (ph_q == 2'd0) prd_q <= pmem[row];
        else begin
          xmem[XAW'(row * WINDOW_LEN + prd_q)] <= val_q;
          pmem[row] <= (prd_q == NW'(WINDOW_LEN - 1)) ? '0 : prd_q + 1'b1;
        end
      end
      StHidPush: begin
        if (ph_q == 2'd0) begin
          prd_q <= (mem_q == '0) ? pmem[lrow] : ptr_q;
          srd_q <= smem[row];
        end else begin
          xmem[XAW'(lrow * WINDOW_LEN + prd_q)] <= srd_q;
          ptr_q <= (prd_q == NW'(WINDOW_LEN - 1)) ? '0 : prd_q + 1'b1;
          if (mem_q == MW'(MEMBERS - 2))
            pmem[lrow] <= (prd_q == NW'(WINDOW_LEN - 1)) ? '0 : prd_q + 1'b1;
        end
      end
      StSumRead: if (ph_q == 2'd0) begin
        wrd_q <= wmem[waddr];
        xrd_q <= xmem[xaddr];
      end
      StSumDone: smem[row] <= sat32(acc_q);
      // Training alternates a read and a write of each weight in turn.
      StTrainRead: begin
        wrd_q <= wmem[waddr];
        srd_q <= smem[row];
      end
      StTrainWrite: wmem[waddr] <= sat32(66'(wrd_q) +
                         ((srd_q <= val_q) ? -66'(delta_q) : 66'(delta_q)));
      default: ;
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      thr_q   <= '0;
      clr_q   <= '0;
      k_q     <= '0;
      ph_q    <= '0;
      mem_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      unique case (state_q)
        StClear: begin
          k_q <= (k_q == LastK) ? '0 : k_q + 1'b1;
          if (k_q == LastK) clr_q <= clr_q + 1'b1;
        end
        StIdle: begin
          circ_q  <= '0;
          addr_q  <= req.vaddr[63:4];
          op_q    <= op_e'(req.op);
          val_q   <= req.value;
          mem_q   <= (op_e'(req.op) == OpTrain) ? MW'(req.member) : '0;
          k_q     <= '0;
          ph_q    <= '0;
        end
        // Four reduction steps; ph_q wraps back to zero for the next phase.
        StHash: begin
          circ_q  <= hash_r[CW-1:0];
          addr_q  <= addr_q << 15;
          ph_q    <= ph_q + 1'b1;
          delta_q <= val_q[31] ? $signed(~dquo + 32'd1) : $signed(dquo);
        end
        StPush, StHidPush: begin
          ph_q <= ph_q ^ 2'd1;
          if (ph_q == 2'd1 && !(state_q == StHidPush && mem_q == MW'(MEMBERS - 2)))
            mem_q <= mem_q + 1'b1;
        end
        StSumInit: begin
          acc_q <= '0;
          k_q   <= '0;
          ph_q  <= '0;
        end
        StSumRead: ph_q <= ph_q + 1'b1;
        StSumMac: begin
          acc_q <= acc_q + ((k_q == '0) ? 66'(wrd_q) : 66'(term));
          k_q   <= k_q + 1'b1;
          ph_q  <= '0;
        end
        StSumDone: begin
          if (mem_q == LastM) begin
            score_q <= sat32(acc_q);
            eo_q    <= sat32(acc_q) <= thr_q;
          end
          if (mem_q == MW'(MEMBERS - 2)) begin
            mem_q <= '0;
            ph_q  <= '0;
          end else if (mem_q != LastM) mem_q <= mem_q + 1'b1;
        end
        StTrainWrite: k_q <= k_q + 1'b1;
        StTrainRead: ;
        default: ;
      endcase
      if (state_q == StHidPush && ph_q == 2'd1 && mem_q == MW'(MEMBERS - 2))
        mem_q <= LastM;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/pepu_mac.sv
`default_nettype none
// Multiply unit: registered 32x32 product, then floor shift by 16.
module pepu_mac (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed [47:0]      term_o
);
  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // Arithmetic shift rounds toward minus infinity.
  assign term_o = prod_q[63:16];
endmodule
`default_nettype wire
